/* src/srsw_pkg.sv */
`default_nettype none
package srsw_pkg;

	localparam int SLOTS = 8;
	localparam int BLOCK_BYTES = 512;
	localparam int HEADER_BYTES = 4;

	localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int IDX_W = 3;
	localparam int LEN_W = 9;
	localparam int SIZE_W = 10;
	localparam int OFF_W = 32;
	localparam int STAMP_W = 8;
	localparam int FUNC_W = 2;

	localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(BLOCK_BYTES - HEADER_BYTES);
	localparam logic [SLOTS-1:0] SLOT_MASK = {SLOTS{1'b1}};

	localparam logic [FUNC_W-1:0] FUNC_FILL = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ACK = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_ACK_RD,
		ST_ACK_CHK,
		ST_FILL,
		ST_DEC,
		ST_SCAN,
		ST_PICK,
		ST_SIZE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic ack_rd;
		logic ack_chk;
		logic fill;
		logic dec;
		logic scan;
		logic pick;
		logic size;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic ack_match;
		logic scan_last;
	} status_t;

endpackage
`default_nettype wire

/* src/srsw_ram.sv */
`default_nettype none
module srsw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* src/srsw_ctrl.sv */
`default_nettype none
module srsw_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire srsw_pkg::status_t status,
	output srsw_pkg::cmd_t cmd,
	output logic busy
);

	import srsw_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (status.func)
					FUNC_FILL: state_d = ST_FILL;
					FUNC_ACK: state_d = ST_ACK_RD;
					FUNC_TICK: state_d = ST_DEC;
					default: state_d = ST_DONE;
				endcase
			end
			ST_ACK_RD: begin
				cmd.ack_rd = 1'b1;
				state_d = ST_ACK_CHK;
			end
			ST_ACK_CHK: begin
				cmd.ack_chk = 1'b1;
				state_d = status.ack_match ? ST_FILL : ST_DONE;
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				state_d = (status.func == FUNC_ACK) ? ST_DEC : ST_DONE;
			end
			ST_DEC: begin
				cmd.dec = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_last) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK: begin
				cmd.pick = 1'b1;
				state_d = ST_SIZE;
			end
			ST_SIZE: begin
				cmd.size = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

/* src/srsw_dp.sv */
`default_nettype none
module srsw_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire srsw_pkg::cmd_t cmd,
	output srsw_pkg::status_t status,
	input wire logic [srsw_pkg::FUNC_W-1:0] func,
	input wire logic [srsw_pkg::IDX_W-1:0] slot,
	input wire logic [srsw_pkg::OFF_W-1:0] ack_offset,
	input wire logic [srsw_pkg::LEN_W-1:0] read_len,
	output logic done,
	output logic accepted,
	output logic filled,
	output logic [srsw_pkg::IDX_W-1:0] filled_slot,
	output logic [srsw_pkg::OFF_W-1:0] filled_offset,
	output logic resend,
	output logic [srsw_pkg::IDX_W-1:0] resend_slot,
	output logic [srsw_pkg::SIZE_W-1:0] resend_size,
	output logic complete,
	output logic source_open
);

	import srsw_pkg::*;

	logic [SLOTS-1:0] free_q;
	logic [STAMP_W-1:0] next_stamp_q;
	logic [OFF_W-1:0] write_off_q;
	logic live_q;
	logic [STAMP_W-1:0] stamp_q [SLOTS];
	logic done_q;

	logic [FUNC_W-1:0] func_q;
	logic [IDX_W-1:0] slot_q;
	logic [OFF_W-1:0] ackoff_q;
	logic [LEN_W-1:0] len_q;

	logic [SLOT_AW-1:0] idx_q;
	logic [STAMP_W-1:0] best_q;
	logic [SLOT_AW-1:0] pick_q;
	logic pick_vld_q;

	logic [SLOT_AW-1:0] lo_idx;
	logic has_free;
	logic [LEN_W-1:0] len_sat;
	logic fill_do;
	logic fill_close;
	logic ack_match;
	logic hit;
	logic [OFF_W-1:0] off_rdata;
	logic [SIZE_W-1:0] size_rdata;
	logic [SIZE_W-1:0] size_wdata;

	// lowest free slot
	always_comb begin
		lo_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				lo_idx = SLOT_AW'(i);
			end
		end
	end

	assign has_free = |free_q;
	assign len_sat = (len_q > LEN_CAP) ? LEN_CAP : len_q;
	assign size_wdata = SIZE_W'(len_sat) + SIZE_W'(HEADER_BYTES);
	assign fill_do = cmd.fill && live_q && has_free && (len_q != '0);
	assign fill_close = cmd.fill && live_q && has_free && (len_q == '0);
	assign ack_match = (int'(slot_q) < SLOTS) && !free_q[slot_q[SLOT_AW-1:0]]
		&& (off_rdata == ackoff_q);
	assign hit = !free_q[idx_q] && ($signed(stamp_q[idx_q]) < $signed(best_q));

	assign status.func = func_q;
	assign status.ack_match = ack_match;
	assign status.scan_last = (idx_q == SLOT_AW'(SLOTS - 1));

	srsw_ram #(.WIDTH(OFF_W), .DEPTH(SLOTS), .AW(SLOT_AW)) u_off_ram (
		.clk(clk),
		.we(fill_do),
		.waddr(lo_idx),
		.wdata(write_off_q),
		.re(cmd.ack_rd),
		.raddr(slot_q[SLOT_AW-1:0]),
		.rdata(off_rdata)
	);

	srsw_ram #(.WIDTH(SIZE_W), .DEPTH(SLOTS), .AW(SLOT_AW)) u_size_ram (
		.clk(clk),
		.we(fill_do),
		.waddr(lo_idx),
		.wdata(size_wdata),
		.re(cmd.pick),
		.raddr(pick_q),
		.rdata(size_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= SLOT_MASK;
			next_stamp_q <= '0;
			write_off_q <= '0;
			live_q <= 1'b1;
			done_q <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				stamp_q[i] <= '0;
			end
		end else begin
			done_q <= cmd.finish;
			if (cmd.ack_chk && ack_match) begin
				free_q[slot_q[SLOT_AW-1:0]] <= 1'b1;
				next_stamp_q <= next_stamp_q - 1'b1;
			end
			if (fill_close) begin
				live_q <= 1'b0;
			end
			if (fill_do) begin
				free_q[lo_idx] <= 1'b0;
				write_off_q <= write_off_q + OFF_W'(len_sat);
				next_stamp_q <= next_stamp_q + 1'b1;
			end
			for (int i = 0; i < SLOTS; i++) begin
				if (fill_do && (lo_idx == SLOT_AW'(i))) begin
					stamp_q[i] <= next_stamp_q;
				end else if (cmd.dec) begin
					stamp_q[i] <= stamp_q[i] - 1'b1;
				end else if (cmd.pick && pick_vld_q && (pick_q == SLOT_AW'(i))) begin
					stamp_q[i] <= next_stamp_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			slot_q <= slot;
			ackoff_q <= ack_offset;
			len_q <= read_len;
			accepted <= 1'b0;
			filled <= 1'b0;
			filled_slot <= '0;
			filled_offset <= '0;
			resend <= 1'b0;
			resend_slot <= '0;
			resend_size <= '0;
			complete <= 1'b0;
			source_open <= 1'b0;
		end
		if (cmd.ack_chk && ack_match) begin
			accepted <= 1'b1;
		end
		if (fill_do) begin
			filled <= 1'b1;
			filled_slot <= IDX_W'(lo_idx);
			filled_offset <= write_off_q;
		end
		// timeout scan, one stamp per cycle
		if (cmd.dec) begin
			idx_q <= '0;
			best_q <= '0;
			pick_q <= '0;
			pick_vld_q <= 1'b0;
		end
		if (cmd.scan) begin
			idx_q <= idx_q + 1'b1;
			if (hit) begin
				best_q <= stamp_q[idx_q];
				pick_q <= idx_q;
				pick_vld_q <= 1'b1;
			end
		end
		if (cmd.pick && pick_vld_q) begin
			resend <= 1'b1;
			resend_slot <= IDX_W'(pick_q);
		end
		if (cmd.size && pick_vld_q) begin
			resend_size <= size_rdata;
		end
		if (cmd.finish) begin
			complete <= (func_q == FUNC_ACK) && (free_q == SLOT_MASK);
			source_open <= live_q;
		end
	end

	assign done = done_q;

endmodule
`default_nettype wire

/* src/selective_repeat_send_window.sv */
`default_nettype none
// channel   signals                                   beat taken when
// command   start, func, slot, ack_offset, read_len   start && !busy
// result    done, accepted .. source_open             done (one cycle, no stall)
//
// busy stays high while a fill, an ack, a tick or the unused code runs; done pulses
// in the first cycle with busy low, once the command's result fields are set.
// the timeout pass walks the eight stamps one per cycle through one signed
// comparator, and offsets and sizes sit in two small registered-read rams.
// reset is immediate: free map, stamps and counters clear on arst_n, no sweep.
// the receiver cannot stall; result fields hold until the next command.
module selective_repeat_send_window (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [srsw_pkg::FUNC_W-1:0] func,
	input wire logic [srsw_pkg::IDX_W-1:0] slot,
	input wire logic [srsw_pkg::OFF_W-1:0] ack_offset,
	input wire logic [srsw_pkg::LEN_W-1:0] read_len,
	output logic done,
	output logic accepted,
	output logic filled,
	output logic [srsw_pkg::IDX_W-1:0] filled_slot,
	output logic [srsw_pkg::OFF_W-1:0] filled_offset,
	output logic resend,
	output logic [srsw_pkg::IDX_W-1:0] resend_slot,
	output logic [srsw_pkg::SIZE_W-1:0] resend_size,
	output logic complete,
	output logic source_open
);

	import srsw_pkg::*;

	cmd_t cmd;
	status_t status;

	srsw_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.status(status),
		.cmd(cmd),
		.busy(busy)
	);

	srsw_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.func(func),
		.slot(slot),
		.ack_offset(ack_offset),
		.read_len(read_len),
		.done(done),
		.accepted(accepted),
		.filled(filled),
		.filled_slot(filled_slot),
		.filled_offset(filled_offset),
		.resend(resend),
		.resend_slot(resend_slot),
		.resend_size(resend_size),
		.complete(complete),
		.source_open(source_open)
	);

endmodule
`default_nettype wire
